### src/aatsc_pkg.sv
`default_nettype none

package aatsc_pkg;

    // field widths of the item channels
    localparam int SAMPLE_W = 14;
    localparam int ABS_W    = 14;
    localparam int COUNT_W  = 32;
    localparam int DIR_W    = 2;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // divisions per turn for each resolution mode
    localparam int unsigned DIV_TABLE [8] = '{200, 128, 64, 32, 256, 160, 96, 48};

    // register map, one word apart
    typedef enum logic [1:0] {
        REG_REVERSED   = 2'd0,
        REG_PPR_MODE   = 2'd1,
        REG_ABS_BITS   = 2'd2,
        REG_COUNT_BITS = 2'd3
    } reg_index_t;

    // reset values of the registers
    localparam logic       REVERSED_RST   = 1'b0;
    localparam logic [2:0] PPR_MODE_RST   = 3'd0;
    localparam logic [4:0] ABS_BITS_RST   = 5'd14;
    localparam logic [5:0] COUNT_BITS_RST = 6'd32;

    // step direction codes
    localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
    localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sb01;
    localparam logic signed [DIR_W-1:0] DIR_DOWN = 2'sb11;

    typedef struct packed {
        logic       reversed;
        logic [2:0] ppr_mode;
        logic [4:0] abs_bits;
        logic [5:0] count_bits;
    } cfg_t;

endpackage

`default_nettype wire

### src/aatsc_in_if.sv
`default_nettype none

interface aatsc_in_if;
    logic                           valid;
    logic                           ready;
    logic [aatsc_pkg::SAMPLE_W-1:0] sample_a;
    logic [aatsc_pkg::SAMPLE_W-1:0] sample_b;
    logic [aatsc_pkg::SAMPLE_W-1:0] sample_c;
    logic [aatsc_pkg::SAMPLE_W-1:0] sample_d;

    modport source (
        output valid, sample_a, sample_b, sample_c, sample_d,
        input  ready
    );

    modport sink (
        input  valid, sample_a, sample_b, sample_c, sample_d,
        output ready
    );
endinterface

`default_nettype wire

### src/aatsc_out_if.sv
`default_nettype none

interface aatsc_out_if;
    logic                               valid;
    logic                               ready;
    logic [aatsc_pkg::ABS_W-1:0]        abs_angle;
    logic [aatsc_pkg::COUNT_W-1:0]      turn_count;
    logic signed [aatsc_pkg::DIR_W-1:0] step_dir;

    modport source (
        output valid, abs_angle, turn_count, step_dir,
        input  ready
    );

    modport sink (
        input  valid, abs_angle, turn_count, step_dir,
        output ready
    );
endinterface

`default_nettype wire

### src/aatsc_cfg.sv
`default_nettype none

module aatsc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aatsc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [aatsc_pkg::PDATA_W-1:0] pwdata,
    output logic      [aatsc_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output aatsc_pkg::cfg_t                    cfg
);

    aatsc_pkg::cfg_t       cfg_reg;
    aatsc_pkg::cfg_t       cfg_next;
    aatsc_pkg::reg_index_t reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = aatsc_pkg::reg_index_t'(paddr[3:2]);
    assign cfg     = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                aatsc_pkg::REG_REVERSED:   cfg_next.reversed   = pwdata[0];
                aatsc_pkg::REG_PPR_MODE:   cfg_next.ppr_mode   = pwdata[2:0];
                aatsc_pkg::REG_ABS_BITS:   cfg_next.abs_bits   = pwdata[4:0];
                aatsc_pkg::REG_COUNT_BITS: cfg_next.count_bits = pwdata[5:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reversed   <= aatsc_pkg::REVERSED_RST;
            cfg_reg.ppr_mode   <= aatsc_pkg::PPR_MODE_RST;
            cfg_reg.abs_bits   <= aatsc_pkg::ABS_BITS_RST;
            cfg_reg.count_bits <= aatsc_pkg::COUNT_BITS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb
    begin
        unique case (reg_idx)
            aatsc_pkg::REG_REVERSED:   prdata = {31'd0, cfg_reg.reversed};
            aatsc_pkg::REG_PPR_MODE:   prdata = {29'd0, cfg_reg.ppr_mode};
            aatsc_pkg::REG_ABS_BITS:   prdata = {27'd0, cfg_reg.abs_bits};
            aatsc_pkg::REG_COUNT_BITS: prdata = {26'd0, cfg_reg.count_bits};
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/aatsc_average.sv
`default_nettype none

module aatsc_average #(
    parameter int ANGLE_WIDTH  = 14,
    parameter int SAMPLE_COUNT = 4
) (
    input  wire logic                           clk,
    input  wire logic                           load,
    input  wire logic                           reversed,
    input  wire logic [aatsc_pkg::SAMPLE_W-1:0] sample_a,
    input  wire logic [aatsc_pkg::SAMPLE_W-1:0] sample_b,
    input  wire logic [aatsc_pkg::SAMPLE_W-1:0] sample_c,
    input  wire logic [aatsc_pkg::SAMPLE_W-1:0] sample_d,
    output logic      [ANGLE_WIDTH-1:0]         angle
);

    localparam int Aw     = ANGLE_WIDTH;
    localparam int Sw     = aatsc_pkg::SAMPLE_W;
    localparam int DiffW  = Aw + 1;
    localparam int SumW   = Aw + 4;
    localparam int Shift  = SumW + 3;
    localparam int ProdW  = SumW + Shift;
    localparam int Arange = 1 << Aw;
    localparam int Center = Arange / 2;
    // rounded-up reciprocal, exact for every sum magnitude that can occur
    localparam int Recip  = ((1 << Shift) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;

    localparam logic signed [DiffW-1:0] CenterPos = DiffW'(Center);
    localparam logic signed [DiffW-1:0] CenterNeg = DiffW'(-Center);
    localparam logic signed [DiffW-1:0] RangeD    = DiffW'(Arange);

    logic [Sw-1:0]              raw [4];
    logic [Aw-1:0]              smp [SAMPLE_COUNT];
    logic signed [DiffW-1:0]    diff [SAMPLE_COUNT];
    logic signed [SumW-1:0]     sum;
    logic [SumW-1:0]            mag;
    logic [ProdW-1:0]           prod;
    logic [Aw-1:0]              quo_mag;
    logic signed [DiffW-1:0]    quo;
    logic [DiffW-1:0]           angle_sum;
    logic [Aw-1:0]              angle_avg;
    logic [Aw-1:0]              angle_reg;

    assign raw[0] = sample_a;
    assign raw[1] = sample_b;
    assign raw[2] = sample_c;
    assign raw[3] = sample_d;

    // samples trimmed to the angle width, extra samples reuse the fourth
    for (genvar i = 0; i < SAMPLE_COUNT; i++)
    begin : g_smp
        localparam int K = (i < 4) ? i : 3;
        logic [Aw+Sw-1:0] ext;
        logic signed [DiffW-1:0] d;

        assign ext     = {{Aw{1'b0}}, raw[K]};
        assign smp[i]  = ext[Aw-1:0];
        assign d       = $signed({1'b0, smp[i]}) - $signed({1'b0, smp[0]});

        // wrap difference into half a turn either way
        always_comb
        begin
            if (d > CenterPos)
                diff[i] = d - RangeD;
            else if (d < CenterNeg)
                diff[i] = d + RangeD;
            else
                diff[i] = d;
        end
    end

    // sum of wrapped differences
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < SAMPLE_COUNT; i++)
            sum = sum + SumW'(diff[i]);
    end

    // divide by sample count, truncating toward zero
    assign mag      = (sum < 0) ? SumW'(-sum) : SumW'(sum);
    assign prod     = ProdW'(mag) * ProdW'(Recip);
    assign quo_mag  = prod[Shift +: Aw];
    assign quo      = (sum < 0) ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});

    // add to the first sample modulo one turn, then optional mirror
    assign angle_sum = {1'b0, smp[0]} + quo;
    assign angle_avg = reversed ? ~angle_sum[Aw-1:0] : angle_sum[Aw-1:0];

    always_ff @(posedge clk)
    begin
        if (load)
            angle_reg <= angle_avg;
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire

### src/aatsc_stepper.sv
`default_nettype none

module aatsc_stepper #(
    parameter int ANGLE_WIDTH = 14
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire aatsc_pkg::cfg_t                    cfg,
    input  wire logic [ANGLE_WIDTH-1:0]             angle,
    output logic      [aatsc_pkg::ABS_W-1:0]        abs_angle,
    output logic      [aatsc_pkg::COUNT_W-1:0]      turn_count,
    output logic signed [aatsc_pkg::DIR_W-1:0]      step_dir
);

    localparam int Aw     = ANGLE_WIDTH;
    localparam int Ow     = aatsc_pkg::ABS_W;
    localparam int Cw     = aatsc_pkg::COUNT_W;
    localparam int DiffW  = Aw + 1;
    localparam int Arange = 1 << Aw;
    localparam int Center = Arange / 2;

    localparam logic signed [DiffW-1:0] CenterPos = DiffW'(Center);
    localparam logic signed [DiffW-1:0] CenterNeg = DiffW'(-Center);
    localparam logic signed [DiffW-1:0] RangeD    = DiffW'(Arange);

    // step size per resolution mode
    localparam logic [Aw-1:0] StepTable [8] = '{
        Aw'(Arange / aatsc_pkg::DIV_TABLE[0]), Aw'(Arange / aatsc_pkg::DIV_TABLE[1]),
        Aw'(Arange / aatsc_pkg::DIV_TABLE[2]), Aw'(Arange / aatsc_pkg::DIV_TABLE[3]),
        Aw'(Arange / aatsc_pkg::DIV_TABLE[4]), Aw'(Arange / aatsc_pkg::DIV_TABLE[5]),
        Aw'(Arange / aatsc_pkg::DIV_TABLE[6]), Aw'(Arange / aatsc_pkg::DIV_TABLE[7])
    };

    logic [Aw-1:0]            ref_reg;
    logic [Aw-1:0]            ref_next;
    logic [Cw-1:0]            count_reg;
    logic [Cw-1:0]            count_next;
    logic [Ow-1:0]            abs_reg;
    logic [Cw-1:0]            cnt_out_reg;
    logic signed [1:0]        dir_reg;
    logic signed [1:0]        dir_next;

    logic signed [DiffW-1:0]  d_raw;
    logic signed [DiffW-1:0]  delta;
    logic [DiffW-1:0]         delta_mag;
    logic [Aw-1:0]            step;
    logic                     do_step;

    logic [4:0]               shamt;
    logic [Aw-1:0]            abs_shift;
    logic [Aw+Ow-1:0]         abs_ext;
    logic [Cw-1:0]            cnt_mask;

    // wrapped distance from the reference
    assign d_raw = $signed({1'b0, angle}) - $signed({1'b0, ref_reg});

    always_comb
    begin
        if (d_raw > CenterPos)
            delta = d_raw - RangeD;
        else if (d_raw < CenterNeg)
            delta = d_raw + RangeD;
        else
            delta = d_raw;
    end

    assign delta_mag = (delta < 0) ? DiffW'(-delta) : DiffW'(delta);
    assign step      = StepTable[cfg.ppr_mode];
    assign do_step   = (delta_mag >= {1'b0, step});

    // one step toward the angle at most
    always_comb
    begin
        ref_next   = ref_reg;
        count_next = count_reg;
        dir_next   = aatsc_pkg::DIR_NONE;
        if (do_step)
        begin
            if (delta > 0)
            begin
                ref_next   = ref_reg + step;
                count_next = count_reg + 1'b1;
                dir_next   = aatsc_pkg::DIR_UP;
            end
            else
            begin
                ref_next   = ref_reg - step;
                count_next = count_reg - 1'b1;
                dir_next   = aatsc_pkg::DIR_DOWN;
            end
        end
    end

    // absolute angle reduced to the configured width
    always_comb
    begin
        if (cfg.abs_bits >= 5'(Aw))
        begin
            shamt = 5'd0;
        end
        else
        begin
            shamt = 5'(Aw) - cfg.abs_bits;
        end
    end

    assign abs_shift = angle >> shamt;
    assign abs_ext   = {{Ow{1'b0}}, abs_shift};

    // counter mask
    always_comb
    begin
        if (cfg.count_bits >= 6'd32)
            cnt_mask = '1;
        else
            cnt_mask = ~({Cw{1'b1}} << cfg.count_bits[4:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg   <= '0;
            count_reg <= '0;
        end
        else if (load)
        begin
            ref_reg   <= ref_next;
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            abs_reg     <= abs_ext[Ow-1:0];
            cnt_out_reg <= count_next & cnt_mask;
            dir_reg     <= dir_next;
        end
    end

    assign abs_angle  = abs_reg;
    assign turn_count = cnt_out_reg;
    assign step_dir   = dir_reg;

endmodule

`default_nettype wire

### src/angle_average_to_step_counter_core.sv
// channel  | dir | handshake     | payload
// in_item  | in  | valid / ready | sample_a, sample_b, sample_c, sample_d
// out_item | out | valid / ready | abs_angle, turn_count, step_dir
// apb      | in  | psel/penable  | paddr, pwdata, prdata, pready (always high)
//
// one item per cycle while out_item is ready; an accepted item passes the
// input register, the averaged angle register and then the result register
// the step counter and reference angle advance in the stepper stage only
// rst_n clears valid flags, configuration, reference angle and counter
// a stall on out_item holds each full stage; an empty stage still takes the item
// behind it, and in_item ready follows from free slots

`default_nettype none

module angle_average_to_step_counter_core #(
    parameter int ANGLE_WIDTH  = 14,
    parameter int SAMPLE_COUNT = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    aatsc_in_if.sink                           in_item,
    aatsc_out_if.source                        out_item,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aatsc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [aatsc_pkg::PDATA_W-1:0] pwdata,
    output logic      [aatsc_pkg::PDATA_W-1:0] prdata,
    output logic                               pready
);

    localparam int Sw = aatsc_pkg::SAMPLE_W;

    aatsc_pkg::cfg_t        cfg;
    logic                   s1_valid_reg;
    logic                   s2_valid_reg;
    logic                   s3_valid_reg;
    logic                   s1_free;
    logic                   s2_free;
    logic                   s3_free;
    logic [Sw-1:0]          a_reg;
    logic [Sw-1:0]          b_reg;
    logic [Sw-1:0]          c_reg;
    logic [Sw-1:0]          d_reg;
    logic [ANGLE_WIDTH-1:0] angle;

    // configuration registers
    aatsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage flow control
    assign s3_free       = !s3_valid_reg || out_item.ready;
    assign s2_free       = !s2_valid_reg || s3_free;
    assign s1_free       = !s1_valid_reg || s2_free;
    assign in_item.ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= in_item.valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (s1_free && in_item.valid)
        begin
            a_reg <= in_item.sample_a;
            b_reg <= in_item.sample_b;
            c_reg <= in_item.sample_c;
            d_reg <= in_item.sample_d;
        end
    end

    // circular average
    aatsc_average #(
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_average (
        .clk      (clk),
        .load     (s1_valid_reg && s2_free),
        .reversed (cfg.reversed),
        .sample_a (a_reg),
        .sample_b (b_reg),
        .sample_c (c_reg),
        .sample_d (d_reg),
        .angle    (angle)
    );

    // reference tracking and step counter
    aatsc_stepper #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_stepper (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s2_valid_reg && s3_free),
        .cfg        (cfg),
        .angle      (angle),
        .abs_angle  (out_item.abs_angle),
        .turn_count (out_item.turn_count),
        .step_dir   (out_item.step_dir)
    );

    assign out_item.valid = s3_valid_reg;

endmodule

`default_nettype wire

### bench/angle_average_to_step_counter_core_test.sv
`timescale 1ns / 100ps

module angle_average_to_step_counter_core_test;

    localparam int SAMPLE_W        = aatsc_pkg::SAMPLE_W;
    localparam int ABS_W           = aatsc_pkg::ABS_W;
    localparam int COUNT_W         = aatsc_pkg::COUNT_W;
    localparam int DIR_W           = aatsc_pkg::DIR_W;
    localparam int PADDR_W         = aatsc_pkg::PADDR_W;
    localparam int PDATA_W         = aatsc_pkg::PDATA_W;

    localparam int TURN            = 1 << SAMPLE_W;
    localparam int LATENCY         = 3;
    localparam int LONG_HOLD       = 200;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int CYCLE_LIMIT     = 200000;

    // corner sample sets sent under the reset configuration
    localparam logic [SAMPLE_W-1:0] CORNER_ITEMS [12][4] = '{
        '{14'd0,     14'd0,     14'd0,     14'd0},
        '{14'd16000, 14'd16000, 14'd16000, 14'd16000},
        '{14'd16383, 14'd16383, 14'd16383, 14'd16383},
        '{14'd0,     14'd16383, 14'd16383, 14'd16383},
        '{14'd16383, 14'd0,     14'd0,     14'd0},
        '{14'd0,     14'd8192,  14'd8192,  14'd8192},
        '{14'd8192,  14'd0,     14'd0,     14'd0},
        '{14'd100,   14'd97,    14'd100,   14'd100},
        '{14'd100,   14'd103,   14'd99,    14'd96},
        '{14'd5461,  14'd10922, 14'd16383, 14'd0},
        '{14'd1,     14'd2,     14'd4,     14'd8},
        '{14'd8191,  14'd8193,  14'd4096,  14'd12288}
    };

    // reversed, abs_bits, count_bits for the fixed phases
    localparam int PHASE_CFG [6][3] = '{
        '{1, 0,  0},
        '{0, 16, 32},
        '{1, 13, 1},
        '{0, 14, 63},
        '{0, 7,  31},
        '{1, 1,  16}
    };

    typedef struct packed {
        logic [ABS_W-1:0]        abs_angle;
        logic [COUNT_W-1:0]      turn_count;
        logic signed [DIR_W-1:0] step_dir;
    } step_result_t;

    // predicts the averaged angle and the step counter, checks each result
    class step_tracker;
        localparam int TURN_SIZE = 1 << SAMPLE_W;
        localparam int SAMPLE_N  = 4;

        aatsc_pkg::cfg_t cfg;
        int              follow_angle;
        logic [31:0]     step_count;
        step_result_t    pending_results[$];
        int              errors;

        function new();
            cfg.reversed   = aatsc_pkg::REVERSED_RST;
            cfg.ppr_mode   = aatsc_pkg::PPR_MODE_RST;
            cfg.abs_bits   = aatsc_pkg::ABS_BITS_RST;
            cfg.count_bits = aatsc_pkg::COUNT_BITS_RST;
            follow_angle   = 0;
            step_count     = '0;
            errors         = 0;
        endfunction

        function void set_register(aatsc_pkg::reg_index_t idx, logic [31:0] value);
            case (idx)
                aatsc_pkg::REG_REVERSED:   cfg.reversed   = value[0];
                aatsc_pkg::REG_PPR_MODE:   cfg.ppr_mode   = value[2:0];
                aatsc_pkg::REG_ABS_BITS:   cfg.abs_bits   = value[4:0];
                aatsc_pkg::REG_COUNT_BITS: cfg.count_bits = value[5:0];
                default:                   ;
            endcase
        endfunction

        // fold a difference into one half turn either way
        function int half_turn(int d);
            if (d > TURN_SIZE / 2)
                return d - TURN_SIZE;
            else if (d < -(TURN_SIZE / 2))
                return d + TURN_SIZE;
            return d;
        endfunction

        function void note_samples(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                   logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] d);
            int           base;
            int           total;
            int           angle;
            int           delta;
            int           step;
            int           mag;
            step_result_t r;

            // circular average around the first sample
            base  = int'(a);
            total = half_turn(int'(b) - base) + half_turn(int'(c) - base)
                  + half_turn(int'(d) - base);
            angle = (base + total / SAMPLE_N + TURN_SIZE) % TURN_SIZE;
            if (cfg.reversed)
                angle = TURN_SIZE - 1 - angle;

            // at most one step of the reference toward the angle
            delta      = half_turn(angle - follow_angle);
            step       = TURN_SIZE / int'(aatsc_pkg::DIV_TABLE[cfg.ppr_mode]);
            mag        = (delta < 0) ? -delta : delta;
            r.step_dir = aatsc_pkg::DIR_NONE;
            if (mag >= step)
            begin
                if (delta > 0)
                begin
                    step_count   = step_count + 32'd1;
                    follow_angle = follow_angle + step;
                    r.step_dir   = aatsc_pkg::DIR_UP;
                end
                else
                begin
                    step_count   = step_count - 32'd1;
                    follow_angle = follow_angle - step;
                    r.step_dir   = aatsc_pkg::DIR_DOWN;
                end
                if (follow_angle >= TURN_SIZE)
                    follow_angle = follow_angle - TURN_SIZE;
                else if (follow_angle < 0)
                    follow_angle = follow_angle + TURN_SIZE;
            end

            // output scaling
            if (int'(cfg.abs_bits) >= SAMPLE_W)
                r.abs_angle = angle[ABS_W-1:0];
            else
                r.abs_angle = ABS_W'(angle >> (SAMPLE_W - int'(cfg.abs_bits)));
            if (cfg.count_bits < 6'd32)
                r.turn_count = step_count & 32'((64'd1 << cfg.count_bits) - 64'd1);
            else
                r.turn_count = step_count;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [ABS_W-1:0] abs_angle,
                                   logic [COUNT_W-1:0] turn_count,
                                   logic signed [DIR_W-1:0] step_dir);
            step_result_t want;

            if (pending_results.size() == 0)
            begin
                $error("result with no item pending: abs_angle %0d turn_count %0d",
                       abs_angle, turn_count);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (abs_angle !== want.abs_angle)
            begin
                $error("abs_angle: expected %0d, got %0d", want.abs_angle, abs_angle);
                errors++;
            end
            if (turn_count !== want.turn_count)
            begin
                $error("turn_count: expected %0h, got %0h", want.turn_count, turn_count);
                errors++;
            end
            if (step_dir !== want.step_dir)
            begin
                $error("step_dir: expected %0d, got %0d", want.step_dir, step_dir);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    bit                  idle_on;
    bit                  hold_asked;
    int                  track;
    step_tracker         tracker;

    aatsc_in_if  in_bus ();
    aatsc_out_if out_bus ();

    angle_average_to_step_counter_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_bus),
        .out_item (out_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // note every accepted item
    always @(posedge clk)
    begin
        if (rst_n && in_bus.valid && in_bus.ready)
            tracker.note_samples(in_bus.sample_a, in_bus.sample_b,
                                 in_bus.sample_c, in_bus.sample_d);
    end

    // check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
            tracker.check_result(out_bus.abs_angle, out_bus.turn_count, out_bus.step_dir);
    end

    // result side: random stall bursts and one long hold on request
    initial
    begin
        out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked)
            begin
                hold_asked = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_bus.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_bus.ready <= 1'b1;
            end
            else
                out_bus.ready <= 1'b1;
        end
    end

    // offer one item and hold it until accepted, then maybe leave a gap
    task automatic send_item(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                             logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] d);
        in_bus.valid    <= 1'b1;
        in_bus.sample_a <= a;
        in_bus.sample_b <= b;
        in_bus.sample_c <= c;
        in_bus.sample_d <= d;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // stop offering and let every pending result come out
    task automatic wait_for_results();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // register write, setup phase then access phase
    task automatic write_register(aatsc_pkg::reg_index_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
        @(posedge clk);
    endtask

    initial
    begin
        int          phase;
        int          pick;
        int          center;
        logic [31:0] reversed_val;
        logic [31:0] abs_val;
        logic [31:0] count_val;
        logic [SAMPLE_W-1:0] sa;
        logic [SAMPLE_W-1:0] sb;
        logic [SAMPLE_W-1:0] sc;
        logic [SAMPLE_W-1:0] sd;

        rst_n           <= 1'b0;
        in_bus.valid    <= 1'b0;
        in_bus.sample_a <= '0;
        in_bus.sample_b <= '0;
        in_bus.sample_c <= '0;
        in_bus.sample_d <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        tracker = new();
        track   = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        // corner sample sets under reset configuration
        for (int i = 0; i < 12; i++)
            send_item(CORNER_ITEMS[i][0], CORNER_ITEMS[i][1],
                      CORNER_ITEMS[i][2], CORNER_ITEMS[i][3]);

        // exactly half a turn ahead of the reference steps up
        wait_for_results();
        center = (tracker.follow_angle + TURN / 2) % TURN;
        send_item(center[SAMPLE_W-1:0], center[SAMPLE_W-1:0],
                  center[SAMPLE_W-1:0], center[SAMPLE_W-1:0]);
        wait_for_results();

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            if (phase < 6)
            begin
                reversed_val = PHASE_CFG[phase][0];
                abs_val      = PHASE_CFG[phase][1];
                count_val    = PHASE_CFG[phase][2];
            end
            else
            begin
                reversed_val = $urandom_range(0, 1);
                abs_val      = $urandom_range(0, 16);
                count_val    = $urandom_range(0, 32);
            end
            write_register(aatsc_pkg::REG_REVERSED, reversed_val);
            write_register(aatsc_pkg::REG_PPR_MODE, phase % 8);
            write_register(aatsc_pkg::REG_ABS_BITS, abs_val);
            write_register(aatsc_pkg::REG_COUNT_BITS, count_val);

            // no idling in the closing phase
            if (phase == PHASES - 1)
                idle_on = 1'b0;
            // result side holds off while items keep coming
            if (phase == 2)
                hold_asked = 1'b1;

            repeat (ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                begin
                    // unrelated samples
                    sa = SAMPLE_W'($urandom_range(0, TURN - 1));
                    sb = SAMPLE_W'($urandom_range(0, TURN - 1));
                    sc = SAMPLE_W'($urandom_range(0, TURN - 1));
                    sd = SAMPLE_W'($urandom_range(0, TURN - 1));
                end
                else
                begin
                    // a turning shaft with jitter, now and then a jump
                    if (pick == 2)
                        track = $urandom_range(0, TURN - 1);
                    else
                        track = (track + int'($urandom_range(0, 400)) - 200 + TURN) % TURN;
                    sa = SAMPLE_W'((track + int'($urandom_range(0, 40)) - 20) & (TURN - 1));
                    sb = SAMPLE_W'((track + int'($urandom_range(0, 40)) - 20) & (TURN - 1));
                    sc = SAMPLE_W'((track + int'($urandom_range(0, 40)) - 20) & (TURN - 1));
                    sd = SAMPLE_W'((track + int'($urandom_range(0, 40)) - 20) & (TURN - 1));
                end
                send_item(sa, sb, sc, sd);
            end
        end

        wait_for_results();
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
